// ----- rtl/cdb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdb_pkg
// Types and constants shared by the common-data-bus writeback block.
// ----------------------------------------------------------------------------
package cdb_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 64;
    localparam int ROB_DEPTH       = 32;

    localparam int CMD_W   = 2;
    localparam int STN_W   = 4;
    localparam int AGE_W   = 32;
    localparam int DTAG_W  = 5;
    localparam int TAG_W   = 6;
    localparam int VAL_W   = 64;
    localparam int EXC_W   = 3;

    localparam logic [TAG_W-1:0] TAG_NONE = TAG_W'(ROB_DEPTH);
    localparam logic [EXC_W-1:0] EXC_CLEAN = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ISSUE     = 2'd0,
        CMD_FINISH    = 2'd1,
        CMD_WRITEBACK = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEL_GROUP,
        ST_SEL_FINAL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [STN_W-1:0]  station;
        logic [AGE_W-1:0]  age;
        logic [DTAG_W-1:0] dest_tag;
        logic [TAG_W-1:0]  src1_tag_in;
        logic [VAL_W-1:0]  src1_value_in;
        logic [TAG_W-1:0]  src2_tag_in;
        logic [VAL_W-1:0]  src2_value_in;
        logic [VAL_W-1:0]  result_in;
        logic [EXC_W-1:0]  exception_in;
    } req_t;

    typedef struct packed {
        logic              broadcast_valid;
        logic [DTAG_W-1:0] broadcast_tag;
        logic [VAL_W-1:0]  broadcast_value;
        logic [EXC_W-1:0]  broadcast_exception;
        logic              read_busy;
        logic [TAG_W-1:0]  read_src1_tag;
        logic [VAL_W-1:0]  read_src1_value;
        logic [TAG_W-1:0]  read_src2_tag;
        logic [VAL_W-1:0]  read_src2_value;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic sel_group;
        logic sel_final;
        logic commit;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic new_is_wb;
        logic out_free;
    } status_t;

    // tags outside the reorder buffer mean "value present"
    function automatic logic [TAG_W-1:0] norm_tag(input logic [TAG_W-1:0] t);
        norm_tag = (t < TAG_NONE) ? t : TAG_NONE;
    endfunction

endpackage

// ----- rtl/cdb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdb_ctrl
// Sequencer: accepts one request, runs the two-step oldest-entry select for
// writebacks, then commits once the response register is free.
// ----------------------------------------------------------------------------
module cdb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  cdb_pkg::status_t status,
    output cdb_pkg::ctrl_t   cmd
);
    import cdb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = status.new_is_wb ? ST_SEL_GROUP : ST_COMMIT;
                end
            end
            ST_SEL_GROUP: state_next = ST_SEL_FINAL;
            ST_SEL_FINAL: state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_SEL_GROUP: cmd.sel_group = 1'b1;
            ST_SEL_FINAL: cmd.sel_final = 1'b1;
            ST_COMMIT:    cmd.commit    = status.out_free;
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while response register is occupied");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_req, cmd.sel_group, cmd.sel_final, cmd.commit}))
        else $error("more than one datapath command");

    a_select_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL_GROUP) |=> (state_reg == ST_SEL_FINAL))
        else $error("select steps out of order");
`endif

endmodule

// ----- rtl/cdb_dp.sv -----
// ----------------------------------------------------------------------------
// cdb_dp
// Datapath: request register, station table, two-step oldest-entry select,
// bus capture and response register.
// ----------------------------------------------------------------------------
module cdb_dp #(
    parameter int NUM_ENTRIES = cdb_pkg::NUM_ENTRIES_DEF,
    parameter int DATA_WIDTH  = cdb_pkg::DATA_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cdb_pkg::req_t    req_data,
    input  cdb_pkg::ctrl_t   cmd,
    output cdb_pkg::status_t status,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output cdb_pkg::rsp_t    rsp_data
);
    import cdb_pkg::*;

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int NG = (NUM_ENTRIES + 3) / 4;   // select groups of four

    // request register
    req_t req_reg;

    // station table
    logic                  busy_reg   [NUM_ENTRIES];
    logic                  busy_next  [NUM_ENTRIES];
    logic                  fin_reg    [NUM_ENTRIES];
    logic                  fin_next   [NUM_ENTRIES];
    logic [AGE_W-1:0]      age_reg    [NUM_ENTRIES];
    logic [DATA_WIDTH-1:0] result_reg [NUM_ENTRIES];
    logic [DTAG_W-1:0]     dest_reg   [NUM_ENTRIES];
    logic [EXC_W-1:0]      exc_reg    [NUM_ENTRIES];
    logic [TAG_W-1:0]      s1tag_reg  [NUM_ENTRIES];
    logic [TAG_W-1:0]      s1tag_next [NUM_ENTRIES];
    logic [DATA_WIDTH-1:0] s1val_reg  [NUM_ENTRIES];
    logic [DATA_WIDTH-1:0] s1val_next [NUM_ENTRIES];
    logic [TAG_W-1:0]      s2tag_reg  [NUM_ENTRIES];
    logic [TAG_W-1:0]      s2tag_next [NUM_ENTRIES];
    logic [DATA_WIDTH-1:0] s2val_reg  [NUM_ENTRIES];
    logic [DATA_WIDTH-1:0] s2val_next [NUM_ENTRIES];

    // select pipeline
    logic             grp_found_reg  [NG];
    logic             grp_found_next [NG];
    logic [IW-1:0]    grp_idx_reg    [NG];
    logic [IW-1:0]    grp_idx_next   [NG];
    logic [AGE_W-1:0] grp_age_reg    [NG];
    logic [AGE_W-1:0] grp_age_next   [NG];
    logic             win_found_reg;
    logic             win_found_next;
    logic [IW-1:0]    win_idx_reg;
    logic [IW-1:0]    win_idx_next;

    // response register
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_data_reg;
    rsp_t rsp_data_next;

    logic              in_range;
    logic [IW-1:0]     st_idx;
    logic              is_wb;
    logic [DTAG_W-1:0] wb_tag;
    logic [EXC_W-1:0]  wb_exc;
    logic [TAG_W-1:0]  wb_tag_ext;

    assign in_range   = 32'(req_reg.station) < NUM_ENTRIES;
    assign st_idx     = IW'(req_reg.station);
    assign is_wb      = (req_reg.command == CMD_WRITEBACK);
    assign wb_tag     = dest_reg[win_idx_reg];
    assign wb_exc     = exc_reg[win_idx_reg];
    assign wb_tag_ext = TAG_W'(wb_tag);

    assign status.new_is_wb = (req_data.command == CMD_WRITEBACK);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp_data         = rsp_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
    end

    // first select step: oldest ready entry inside each group of four
    always_comb
    begin
        int i;
        for (int g = 0; g < NG; g++)
        begin
            grp_found_next[g] = 1'b0;
            grp_idx_next[g]   = '0;
            grp_age_next[g]   = '0;
            for (int k = 0; k < 4; k++)
            begin
                i = g * 4 + k;
                if (i < NUM_ENTRIES)
                begin
                    if (busy_reg[i] && fin_reg[i] &&
                        (!grp_found_next[g] || age_reg[i] < grp_age_next[g]))
                    begin
                        grp_found_next[g] = 1'b1;
                        grp_idx_next[g]   = IW'(i);
                        grp_age_next[g]   = age_reg[i];
                    end
                end
            end
        end
    end

    // second step: across groups; strict compare keeps the lowest index on ties
    always_comb
    begin
        logic [AGE_W-1:0] best;
        best           = '0;
        win_found_next = 1'b0;
        win_idx_next   = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (grp_found_reg[g] && (!win_found_next || grp_age_reg[g] < best))
            begin
                win_found_next = 1'b1;
                win_idx_next   = grp_idx_reg[g];
                best           = grp_age_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel_group)
        begin
            for (int g = 0; g < NG; g++)
            begin
                grp_found_reg[g] <= grp_found_next[g];
                grp_idx_reg[g]   <= grp_idx_next[g];
                grp_age_reg[g]   <= grp_age_next[g];
            end
        end
        if (cmd.sel_final)
        begin
            win_found_reg <= win_found_next;
            win_idx_reg   <= win_idx_next;
        end
    end

    // table update on commit
    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            busy_next[i]  = busy_reg[i];
            fin_next[i]   = fin_reg[i];
            s1tag_next[i] = s1tag_reg[i];
            s1val_next[i] = s1val_reg[i];
            s2tag_next[i] = s2tag_reg[i];
            s2val_next[i] = s2val_reg[i];
        end
        if (cmd.commit)
        begin
            case (req_reg.command)
                CMD_ISSUE:
                begin
                    if (in_range)
                    begin
                        busy_next[st_idx]  = 1'b1;
                        fin_next[st_idx]   = 1'b0;
                        s1tag_next[st_idx] = norm_tag(req_reg.src1_tag_in);
                        s1val_next[st_idx] = DATA_WIDTH'(req_reg.src1_value_in);
                        s2tag_next[st_idx] = norm_tag(req_reg.src2_tag_in);
                        s2val_next[st_idx] = DATA_WIDTH'(req_reg.src2_value_in);
                    end
                end
                CMD_FINISH:
                begin
                    if (in_range)
                    begin
                        fin_next[st_idx] = 1'b1;
                    end
                end
                CMD_WRITEBACK:
                begin
                    if (win_found_reg)
                    begin
                        busy_next[win_idx_reg] = 1'b0;
                        fin_next[win_idx_reg]  = 1'b0;
                        if (wb_exc == EXC_CLEAN)
                        begin
                            // capture on every entry, busy or not
                            for (int i = 0; i < NUM_ENTRIES; i++)
                            begin
                                if (s1tag_reg[i] == wb_tag_ext)
                                begin
                                    s1tag_next[i] = TAG_NONE;
                                    s1val_next[i] = result_reg[win_idx_reg];
                                end
                                if (s2tag_reg[i] == wb_tag_ext)
                                begin
                                    s2tag_next[i] = TAG_NONE;
                                    s2val_next[i] = result_reg[win_idx_reg];
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    busy_next[0] = busy_reg[0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                busy_reg[i]  <= 1'b0;
                fin_reg[i]   <= 1'b0;
                s1tag_reg[i] <= TAG_NONE;
                s1val_reg[i] <= '0;
                s2tag_reg[i] <= TAG_NONE;
                s2val_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                busy_reg[i]  <= busy_next[i];
                fin_reg[i]   <= fin_next[i];
                s1tag_reg[i] <= s1tag_next[i];
                s1val_reg[i] <= s1val_next[i];
                s2tag_reg[i] <= s2tag_next[i];
                s2val_reg[i] <= s2val_next[i];
            end
        end
    end

    // fields with no reset value
    always_ff @(posedge clk)
    begin
        if (cmd.commit && in_range)
        begin
            if (req_reg.command == CMD_ISSUE)
            begin
                age_reg[st_idx]  <= req_reg.age;
                dest_reg[st_idx] <= req_reg.dest_tag;
            end
            if (req_reg.command == CMD_FINISH)
            begin
                result_reg[st_idx] <= DATA_WIDTH'(req_reg.result_in);
                exc_reg[st_idx]    <= req_reg.exception_in;
            end
        end
    end

    // response
    always_comb
    begin
        rsp_data_next = '0;
        case (req_reg.command)
            CMD_WRITEBACK:
            begin
                if (win_found_reg)
                begin
                    rsp_data_next.broadcast_valid     = 1'b1;
                    rsp_data_next.broadcast_tag       = wb_tag;
                    rsp_data_next.broadcast_value     = VAL_W'(result_reg[win_idx_reg]);
                    rsp_data_next.broadcast_exception = wb_exc;
                end
            end
            CMD_READ:
            begin
                if (in_range)
                begin
                    rsp_data_next.read_busy       = busy_reg[st_idx];
                    rsp_data_next.read_src1_tag   = s1tag_reg[st_idx];
                    rsp_data_next.read_src1_value = VAL_W'(s1val_reg[st_idx]);
                    rsp_data_next.read_src2_tag   = s2tag_reg[st_idx];
                    rsp_data_next.read_src2_value = VAL_W'(s2val_reg[st_idx]);
                end
            end
            default:
            begin
                rsp_data_next = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

`ifndef SYNTH
    a_winner_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_wb && win_found_reg)
            |-> (busy_reg[win_idx_reg] && fin_reg[win_idx_reg]))
        else $error("writeback winner is not a busy, finished entry");

    a_winner_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_wb && win_found_reg)
            |=> !busy_reg[$past(win_idx_reg)])
        else $error("writeback did not free the winning entry");
`endif

endmodule

// ----- rtl/tomasulo_cdb_writeback_top.sv -----
// ----------------------------------------------------------------------------
// tomasulo_cdb_writeback_top
// Common-data-bus writeback stage: reservation-station table with oldest
// finished entry broadcast and operand capture.
//
//   channel | signals                          | payload
//   --------+----------------------------------+---------------------------
//   request | req_valid, req_ready, req_data   | cdb_pkg::req_t (command)
//   result  | rsp_valid, rsp_ready, rsp_data   | cdb_pkg::rsp_t (one/request)
//
// Issue, finish and read go from accept straight to the commit state;
// writeback first runs the oldest-age select (groups of four, then
// across groups) ahead of the commit state.
// One request is in flight; a new one is taken while a result waits in the
// response register, but it commits only once that register is free.
// Reset is asynchronous and clears busy/finished flags and source operands.
// ----------------------------------------------------------------------------
module tomasulo_cdb_writeback_top #(
    parameter int NUM_ENTRIES = cdb_pkg::NUM_ENTRIES_DEF,
    parameter int DATA_WIDTH  = cdb_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cdb_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cdb_pkg::rsp_t rsp_data
);
    import cdb_pkg::*;

    ctrl_t   cmd;
    status_t status;

    cdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cdb_dp #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
